>>> hdl/polyline_arc_length_resampler_top_defines.svh
// ----------------------------------------------------------------------------
// Polyline resampler assertion macros
// Shared concurrent assertion forms, clocked on i_clk with reset held off.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_ARC_LENGTH_RESAMPLER_TOP_DEFINES_SVH
`define POLYLINE_ARC_LENGTH_RESAMPLER_TOP_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define PALR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define PALR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define PALR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/palr_pkg.sv
// ----------------------------------------------------------------------------
// Polyline resampler package
// Constants, datapath operation codes and the command and status structures
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package palr_pkg;

    // Design constants.
    localparam int MAX_SEGMENT_SAMPLES = 62;
    localparam int COORD_FRAC_BITS     = 16;
    localparam int SEG_CNT_W           = $clog2(MAX_SEGMENT_SAMPLES + 1);
    localparam int ITER_W              = 6;

    // Tolerances in coordinate LSBs: 1e-6 m and 1e-9 m.
    localparam longint DUP_EPS_VAL = (64'd1 << COORD_FRAC_BITS) / 64'd1000000;
    localparam longint SEG_EPS_VAL = (64'd1 << COORD_FRAC_BITS) / 64'd1000000000;
    localparam logic [32:0] DUP_EPS = 33'(DUP_EPS_VAL);
    localparam logic [48:0] SEG_EPS = 49'(SEG_EPS_VAL);

    localparam logic [47:0] MAX48          = 48'hFFFF_FFFF_FFFF;
    localparam logic [20:0] SPACING_RESET  = 21'd3277;

    // Iteration counts of the shared sequential unit, minus one.
    localparam logic [ITER_W-1:0] ROOT_STEPS_M1 = ITER_W'(32);
    localparam logic [ITER_W-1:0] DIV_STEPS_M1  = ITER_W'(32);
    localparam logic [ITER_W-1:0] SKIP_STEPS_M1 = ITER_W'(48);

    // Datapath operations.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIRST,
        OP_DIFF_SEG,
        OP_DIFF_GAP,
        OP_SQA,
        OP_SQB,
        OP_SQSUM,
        OP_ROOT_STEP,
        OP_SEGCHK,
        OP_OVFCHK,
        OP_CHK,
        OP_MULLO,
        OP_MULHI,
        OP_MULSUM,
        OP_DIVINIT,
        OP_DIV_STEP,
        OP_ROUND,
        OP_EMIT,
        OP_SKIPINIT,
        OP_SKIPFIN,
        OP_SEGFIN,
        OP_OUT_HELD,
        OP_OUT_HELD_LAST,
        OP_OUT_PREV_LAST,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op  op;
        logic axis;    // 0 selects x, 1 selects y
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic in_end;
        logic root_gt_eps;
        logic replace;
        logic loop_go;
        logic nsa_le;
        logic iter_done;
        logic held_valid;
        logic can_load;
    } t_stat;

endpackage

`default_nettype wire

>>> hdl/palr_dpath.sv
// ----------------------------------------------------------------------------
// Polyline resampler datapath
// Path state, one shared 32x32 multiplier, a one-bit-per-cycle square root
// and divider unit, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_arc_length_resampler_top_defines.svh"

module palr_dpath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [20:0]         i_cfg_wr_data,
    input  wire logic signed [31:0]  i_point_x,
    input  wire logic signed [31:0]  i_point_y,
    input  wire logic                i_path_end,
    input  wire logic                i_out_stall,
    output logic                     o_out_valid,
    output logic signed [31:0]       o_sample_x,
    output logic signed [31:0]       o_sample_y,
    output logic                     o_sample_last,
    output logic                     o_cap_overflow,
    input  wire palr_pkg::t_cmd      i_cmd,
    output palr_pkg::t_stat          o_stat
);

    localparam logic [palr_pkg::ITER_W-1:0]    ITER_ONE = palr_pkg::ITER_W'(1);
    localparam logic [palr_pkg::SEG_CNT_W-1:0] SEG_ONE  = palr_pkg::SEG_CNT_W'(1);

    // Control registers.
    logic [20:0]                    r_spacing;
    logic                           r_have_prev;
    logic                           r_held_valid;
    logic [1:0]                     r_samples;
    logic [47:0]                    r_run;
    logic [47:0]                    r_nsa;
    logic                           r_ovf;
    logic [palr_pkg::SEG_CNT_W-1:0] r_seg_cnt;
    logic [palr_pkg::ITER_W-1:0]    r_iter;
    logic                           r_out_valid;

    // Payload registers.
    logic [31:0] r_in_x, r_in_y, r_prev_x, r_prev_y, r_held_x, r_held_y;
    logic [31:0] r_new_x, r_new_y;
    logic        r_in_end;
    logic [31:0] r_ux, r_uy;
    logic        r_negx, r_negy;
    logic [32:0] r_len;
    logic [48:0] r_limit;
    logic [49:0] r_far;
    logic [32:0] r_off;
    logic [65:0] r_acc;
    logic [63:0] r_mulq;
    logic [65:0] r_sh;
    logic [34:0] r_rem;
    logic [32:0] r_res;
    logic [32:0] r_dvs;
    logic [31:0] r_out_x, r_out_y;
    logic        r_out_last, r_out_ovf;

    // Effective spacing: a zero register acts as one.
    logic [20:0] w_sp;
    assign w_sp = (r_spacing == 21'd0) ? 21'd1 : r_spacing;

    // Difference magnitudes, for a segment or for the end gap.
    logic [31:0]        w_ax, w_ay, w_bx, w_by;
    logic signed [32:0] w_dx, w_dy;
    logic [32:0]        w_ndx, w_ndy;
    always_comb begin
        if (i_cmd.op == palr_pkg::OP_DIFF_GAP) begin
            w_ax = r_held_x;
            w_ay = r_held_y;
            w_bx = r_prev_x;
            w_by = r_prev_y;
        end else begin
            w_ax = r_prev_x;
            w_ay = r_prev_y;
            w_bx = r_in_x;
            w_by = r_in_y;
        end
    end
    assign w_dx  = $signed({w_bx[31], w_bx}) - $signed({w_ax[31], w_ax});
    assign w_dy  = $signed({w_by[31], w_by}) - $signed({w_ay[31], w_ay});
    assign w_ndx = 33'd0 - w_dx;
    assign w_ndy = 33'd0 - w_dy;

    // Shared multiplier.
    logic [31:0] w_mag;
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_mul_p;
    assign w_mag = i_cmd.axis ? r_uy : r_ux;
    always_comb begin
        unique case (i_cmd.op)
            palr_pkg::OP_SQA: begin
                w_mul_a = r_ux;
                w_mul_b = r_ux;
            end
            palr_pkg::OP_SQB: begin
                w_mul_a = r_uy;
                w_mul_b = r_uy;
            end
            palr_pkg::OP_MULLO: begin
                w_mul_a = w_mag;
                w_mul_b = {15'd0, r_off[16:0]};
            end
            palr_pkg::OP_MULHI: begin
                w_mul_a = w_mag;
                w_mul_b = {16'd0, r_off[32:17]};
            end
            default: begin
                w_mul_a = w_mag;
                w_mul_b = 32'd0;
            end
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    // Square root step: two radicand bits per cycle.
    logic [36:0] w_rt_t, w_rt_trial, w_rt_rem;
    logic        w_rt_ge;
    assign w_rt_t     = {r_rem, r_sh[65:64]};
    assign w_rt_trial = {2'b00, r_res, 2'b01};
    assign w_rt_ge    = (w_rt_t >= w_rt_trial);
    assign w_rt_rem   = w_rt_ge ? (w_rt_t - w_rt_trial) : w_rt_t;

    // Division step: one numerator bit per cycle.
    logic [34:0] w_dv_t, w_dv_d, w_dv_rem;
    logic        w_dv_ge;
    assign w_dv_t   = {r_rem[33:0], r_sh[65]};
    assign w_dv_d   = {2'b00, r_dvs};
    assign w_dv_ge  = (w_dv_t >= w_dv_d);
    assign w_dv_rem = w_dv_ge ? (w_dv_t - w_dv_d) : w_dv_t;

    // Rounding and the interpolated coordinate.
    logic        w_rnd_up;
    logic [32:0] w_q;
    logic [31:0] w_base, w_coord;
    logic        w_neg;
    assign w_rnd_up = ({r_rem[33:0], 1'b0} >= {2'b00, r_dvs});
    assign w_q      = r_res + {32'd0, w_rnd_up};
    assign w_base   = i_cmd.axis ? r_prev_y : r_prev_x;
    assign w_neg    = i_cmd.axis ? r_negy : r_negx;
    assign w_coord  = w_neg ? (w_base - w_q[31:0]) : (w_base + w_q[31:0]);

    // Offset of the next sample into the segment, clamped to its length.
    logic [47:0] w_off_raw;
    logic [32:0] w_off;
    assign w_off_raw = (r_nsa >= r_run) ? (r_nsa - r_run) : 48'd0;
    assign w_off     = (w_off_raw > {15'd0, r_len}) ? r_len : w_off_raw[32:0];

    // Saturating distance updates.
    logic [48:0] w_nsa_add, w_run_add, w_skip_d;
    logic [49:0] w_skip_sum;
    logic [47:0] w_far_sat;
    assign w_nsa_add  = {1'b0, r_nsa} + 49'(w_sp);
    assign w_run_add  = {1'b0, r_run} + 49'(r_len);
    assign w_skip_d   = r_limit - {1'b0, r_nsa};
    assign w_skip_sum = {1'b0, r_limit} - 50'(r_rem) + 50'(w_sp);
    assign w_far_sat  = (r_far > {2'b00, palr_pkg::MAX48}) ? palr_pkg::MAX48 : r_far[47:0];

    // Output loading.
    logic w_can_load, w_emit_go, w_out_load;
    assign w_can_load = !r_out_valid || !i_out_stall;
    assign w_emit_go  = !r_held_valid || w_can_load;
    always_comb begin
        unique case (i_cmd.op)
            palr_pkg::OP_EMIT:          w_out_load = r_held_valid && w_can_load;
            palr_pkg::OP_OUT_HELD,
            palr_pkg::OP_OUT_HELD_LAST,
            palr_pkg::OP_OUT_PREV_LAST: w_out_load = w_can_load;
            default:                    w_out_load = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing    <= palr_pkg::SPACING_RESET;
            r_have_prev  <= 1'b0;
            r_held_valid <= 1'b0;
            r_samples    <= 2'd0;
            r_run        <= 48'd0;
            r_nsa        <= 48'd0;
            r_ovf        <= 1'b0;
            r_seg_cnt    <= '0;
            r_iter       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_spacing <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                palr_pkg::OP_LOAD: begin
                    r_ovf <= 1'b0;
                end
                palr_pkg::OP_FIRST: begin
                    r_have_prev  <= 1'b1;
                    r_held_valid <= 1'b1;
                    r_samples    <= 2'd1;
                    r_run        <= 48'd0;
                    r_nsa        <= 48'(w_sp);
                end
                palr_pkg::OP_SQSUM: begin
                    r_iter <= palr_pkg::ROOT_STEPS_M1;
                end
                palr_pkg::OP_DIVINIT: begin
                    r_iter <= palr_pkg::DIV_STEPS_M1;
                end
                palr_pkg::OP_SKIPINIT: begin
                    r_iter <= palr_pkg::SKIP_STEPS_M1;
                end
                palr_pkg::OP_ROOT_STEP,
                palr_pkg::OP_DIV_STEP: begin
                    r_iter <= r_iter - ITER_ONE;
                end
                palr_pkg::OP_SEGCHK: begin
                    r_seg_cnt <= '0;
                end
                palr_pkg::OP_OVFCHK: begin
                    r_ovf <= ({1'b0, w_far_sat} <= r_limit);
                end
                palr_pkg::OP_EMIT: begin
                    if (w_emit_go) begin
                        r_held_valid <= 1'b1;
                        if (r_samples != 2'd3) begin
                            r_samples <= r_samples + 2'd1;
                        end
                        r_seg_cnt <= r_seg_cnt + SEG_ONE;
                        r_nsa     <= w_nsa_add[48] ? palr_pkg::MAX48 : w_nsa_add[47:0];
                    end
                end
                palr_pkg::OP_SKIPFIN: begin
                    r_nsa <= (w_skip_sum > {2'b00, palr_pkg::MAX48}) ? palr_pkg::MAX48
                                                                     : w_skip_sum[47:0];
                end
                palr_pkg::OP_SEGFIN: begin
                    r_run <= w_run_add[48] ? palr_pkg::MAX48 : w_run_add[47:0];
                end
                palr_pkg::OP_CLEAR: begin
                    r_have_prev  <= 1'b0;
                    r_held_valid <= 1'b0;
                    r_samples    <= 2'd0;
                    r_run        <= 48'd0;
                    r_nsa        <= 48'd0;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ovf <= r_ovf;
            if (i_cmd.op == palr_pkg::OP_OUT_PREV_LAST) begin
                r_out_x    <= r_prev_x;
                r_out_y    <= r_prev_y;
                r_out_last <= 1'b1;
            end else begin
                r_out_x    <= r_held_x;
                r_out_y    <= r_held_y;
                r_out_last <= (i_cmd.op == palr_pkg::OP_OUT_HELD_LAST);
            end
        end
        unique case (i_cmd.op)
            palr_pkg::OP_LOAD: begin
                r_in_x   <= i_point_x;
                r_in_y   <= i_point_y;
                r_in_end <= i_path_end;
            end
            palr_pkg::OP_FIRST: begin
                r_prev_x <= r_in_x;
                r_prev_y <= r_in_y;
                r_held_x <= r_in_x;
                r_held_y <= r_in_y;
            end
            palr_pkg::OP_DIFF_SEG,
            palr_pkg::OP_DIFF_GAP: begin
                r_ux   <= w_dx[32] ? w_ndx[31:0] : w_dx[31:0];
                r_uy   <= w_dy[32] ? w_ndy[31:0] : w_dy[31:0];
                r_negx <= w_dx[32];
                r_negy <= w_dy[32];
            end
            palr_pkg::OP_SQA,
            palr_pkg::OP_MULLO: begin
                r_acc <= 66'(w_mul_p);
            end
            palr_pkg::OP_SQB,
            palr_pkg::OP_MULHI: begin
                r_mulq <= w_mul_p;
            end
            palr_pkg::OP_SQSUM: begin
                r_sh  <= r_acc + 66'(r_mulq);
                r_rem <= 35'd0;
                r_res <= 33'd0;
            end
            palr_pkg::OP_ROOT_STEP: begin
                r_rem <= w_rt_rem[34:0];
                r_res <= {r_res[31:0], w_rt_ge};
                r_sh  <= {r_sh[63:0], 2'b00};
            end
            palr_pkg::OP_SEGCHK: begin
                r_len   <= r_res;
                r_limit <= {1'b0, r_run} + 49'(r_res) + palr_pkg::SEG_EPS;
                r_far   <= {2'b00, r_nsa}
                           + 50'(w_sp) * 50'(palr_pkg::MAX_SEGMENT_SAMPLES);
            end
            palr_pkg::OP_CHK: begin
                r_off <= w_off;
            end
            palr_pkg::OP_MULSUM: begin
                r_sh <= r_acc + 66'({r_mulq, 17'd0});
            end
            palr_pkg::OP_DIVINIT: begin
                r_rem <= {2'b00, r_sh[65:33]};
                r_sh  <= {r_sh[32:0], 33'd0};
                r_res <= 33'd0;
                r_dvs <= r_len;
            end
            palr_pkg::OP_DIV_STEP: begin
                r_rem <= w_dv_rem;
                r_res <= {r_res[31:0], w_dv_ge};
                r_sh  <= {r_sh[64:0], 1'b0};
            end
            palr_pkg::OP_ROUND: begin
                if (i_cmd.axis) begin
                    r_new_y <= w_coord;
                end else begin
                    r_new_x <= w_coord;
                end
            end
            palr_pkg::OP_EMIT: begin
                if (w_emit_go) begin
                    r_held_x <= r_new_x;
                    r_held_y <= r_new_y;
                end
            end
            palr_pkg::OP_SKIPINIT: begin
                r_sh  <= {w_skip_d, 17'd0};
                r_rem <= 35'd0;
                r_res <= 33'd0;
                r_dvs <= 33'(w_sp);
            end
            palr_pkg::OP_SEGFIN: begin
                r_prev_x <= r_in_x;
                r_prev_y <= r_in_y;
            end
            default: begin
            end
        endcase
    end

    // Status back to the controller.
    always_comb begin
        o_stat.have_prev   = r_have_prev;
        o_stat.in_end      = r_in_end;
        o_stat.root_gt_eps = (r_res > palr_pkg::DUP_EPS);
        o_stat.replace     = (r_samples >= 2'd2) && ({r_res, 1'b0} < 34'(w_sp));
        o_stat.loop_go     = (r_seg_cnt < palr_pkg::SEG_CNT_W'(palr_pkg::MAX_SEGMENT_SAMPLES))
                             && ({1'b0, r_nsa} <= r_limit);
        o_stat.nsa_le      = ({1'b0, r_nsa} <= r_limit);
        o_stat.iter_done   = (r_iter == '0);
        o_stat.held_valid  = r_held_valid;
        o_stat.can_load    = w_can_load;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_x     = r_out_x;
    assign o_sample_y     = r_out_y;
    assign o_sample_last  = r_out_last;
    assign o_cap_overflow = r_out_ovf;

    // An open path always has a held sample and at least one sample counted.
    `PALR_ASSERT_ALWAYS(a_held_tracks_path, r_held_valid == r_have_prev,
        "held sample validity differs from path state")
    `PALR_ASSERT_ALWAYS(a_count_tracks_path, (r_samples == 2'd0) == !r_have_prev,
        "sample count inconsistent with path state")
    `PALR_ASSERT_ALWAYS(a_seg_cap,
        r_seg_cnt <= palr_pkg::SEG_CNT_W'(palr_pkg::MAX_SEGMENT_SAMPLES),
        "segment sample count beyond cap")

endmodule

`default_nettype wire

>>> hdl/palr_ctrl.sv
// ----------------------------------------------------------------------------
// Polyline resampler controller
// One-hot sequencer that steps the datapath through each vertex: segment
// length, sample loop, cap skip and the path end decision.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_arc_length_resampler_top_defines.svh"

module palr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire palr_pkg::t_stat i_stat,
    output palr_pkg::t_cmd       o_cmd
);

    typedef enum logic [24:0] {
        S_IDLE     = 25'b1 << 0,
        S_FIRST    = 25'b1 << 1,
        S_DIFF     = 25'b1 << 2,
        S_SQA      = 25'b1 << 3,
        S_SQB      = 25'b1 << 4,
        S_SQSUM    = 25'b1 << 5,
        S_ROOT     = 25'b1 << 6,
        S_SEGCHK   = 25'b1 << 7,
        S_OVFCHK   = 25'b1 << 8,
        S_CHK      = 25'b1 << 9,
        S_MULLO    = 25'b1 << 10,
        S_MULHI    = 25'b1 << 11,
        S_MULSUM   = 25'b1 << 12,
        S_DIVINIT  = 25'b1 << 13,
        S_DIV      = 25'b1 << 14,
        S_ROUND    = 25'b1 << 15,
        S_EMIT     = 25'b1 << 16,
        S_SKIPINIT = 25'b1 << 17,
        S_SKIP     = 25'b1 << 18,
        S_SKIPFIN  = 25'b1 << 19,
        S_SEGFIN   = 25'b1 << 20,
        S_GAPDEC   = 25'b1 << 21,
        S_OUTA     = 25'b1 << 22,
        S_OUTB     = 25'b1 << 23,
        S_CLEAR    = 25'b1 << 24
    } t_state;

    t_state r_state, n_state;
    logic   r_gap, n_gap;
    logic   r_axis, n_axis;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Next state and datapath command.
    always_comb begin
        n_state   = r_state;
        n_gap     = r_gap;
        n_axis    = r_axis;
        o_cmd.op  = palr_pkg::OP_NONE;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.op = palr_pkg::OP_LOAD;
                    n_gap    = 1'b0;
                    n_state  = i_stat.have_prev ? S_DIFF : S_FIRST;
                end
            end
            S_FIRST: begin
                o_cmd.op = palr_pkg::OP_FIRST;
                if (i_stat.in_end) begin
                    n_gap   = 1'b1;
                    n_state = S_DIFF;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIFF: begin
                o_cmd.op = r_gap ? palr_pkg::OP_DIFF_GAP : palr_pkg::OP_DIFF_SEG;
                n_state  = S_SQA;
            end
            S_SQA: begin
                o_cmd.op = palr_pkg::OP_SQA;
                n_state  = S_SQB;
            end
            S_SQB: begin
                o_cmd.op = palr_pkg::OP_SQB;
                n_state  = S_SQSUM;
            end
            S_SQSUM: begin
                o_cmd.op = palr_pkg::OP_SQSUM;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = palr_pkg::OP_ROOT_STEP;
                if (i_stat.iter_done) begin
                    n_state = r_gap ? S_GAPDEC : S_SEGCHK;
                end
            end
            S_SEGCHK: begin
                o_cmd.op = palr_pkg::OP_SEGCHK;
                if (i_stat.root_gt_eps) begin
                    n_state = S_OVFCHK;
                end else if (i_stat.in_end) begin
                    n_gap   = 1'b1;
                    n_state = S_DIFF;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OVFCHK: begin
                o_cmd.op = palr_pkg::OP_OVFCHK;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.op = palr_pkg::OP_CHK;
                priority if (i_stat.loop_go) begin
                    n_axis  = 1'b0;
                    n_state = S_MULLO;
                end else if (i_stat.nsa_le) begin
                    n_state = S_SKIPINIT;
                end else begin
                    n_state = S_SEGFIN;
                end
            end
            S_MULLO: begin
                o_cmd.op = palr_pkg::OP_MULLO;
                n_state  = S_MULHI;
            end
            S_MULHI: begin
                o_cmd.op = palr_pkg::OP_MULHI;
                n_state  = S_MULSUM;
            end
            S_MULSUM: begin
                o_cmd.op = palr_pkg::OP_MULSUM;
                n_state  = S_DIVINIT;
            end
            S_DIVINIT: begin
                o_cmd.op = palr_pkg::OP_DIVINIT;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = palr_pkg::OP_DIV_STEP;
                if (i_stat.iter_done) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.op = palr_pkg::OP_ROUND;
                if (r_axis) begin
                    n_state = S_EMIT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_MULLO;
                end
            end
            S_EMIT: begin
                o_cmd.op = palr_pkg::OP_EMIT;
                if (!i_stat.held_valid || i_stat.can_load) begin
                    n_state = S_CHK;
                end
            end
            S_SKIPINIT: begin
                o_cmd.op = palr_pkg::OP_SKIPINIT;
                n_state  = S_SKIP;
            end
            S_SKIP: begin
                o_cmd.op = palr_pkg::OP_DIV_STEP;
                if (i_stat.iter_done) begin
                    n_state = S_SKIPFIN;
                end
            end
            S_SKIPFIN: begin
                o_cmd.op = palr_pkg::OP_SKIPFIN;
                n_state  = S_SEGFIN;
            end
            S_SEGFIN: begin
                o_cmd.op = palr_pkg::OP_SEGFIN;
                if (i_stat.in_end) begin
                    n_gap   = 1'b1;
                    n_state = S_DIFF;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_GAPDEC: begin
                n_state = (i_stat.root_gt_eps && !i_stat.replace) ? S_OUTA : S_OUTB;
            end
            S_OUTA: begin
                o_cmd.op = palr_pkg::OP_OUT_HELD;
                if (i_stat.can_load) begin
                    n_state = S_OUTB;
                end
            end
            S_OUTB: begin
                o_cmd.op = i_stat.root_gt_eps ? palr_pkg::OP_OUT_PREV_LAST
                                              : palr_pkg::OP_OUT_HELD_LAST;
                if (i_stat.can_load) begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.op = palr_pkg::OP_CLEAR;
                n_gap    = 1'b0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gap   <= 1'b0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gap   <= n_gap;
            r_axis  <= n_axis;
        end
    end

    `PALR_ASSERT_SAME(a_segchk_after_root, r_state == S_SEGCHK, $past(r_state) == S_ROOT,
        "segment check not preceded by square root")
    `PALR_ASSERT_NEXT(a_accept_starts, w_accept, (r_state == S_FIRST) || (r_state == S_DIFF),
        "accepted vertex did not start processing")
    `PALR_ASSERT_NEXT(a_y_then_emit, (r_state == S_ROUND) && r_axis, r_state == S_EMIT,
        "second coordinate not followed by emission")

endmodule

`default_nettype wire

>>> hdl/polyline_arc_length_resampler_top.sv
// ----------------------------------------------------------------------------
// Polyline arc-length resampler
// Resamples a stream of Q16.16 path vertices at a fixed arc-length spacing.
// ----------------------------------------------------------------------------
// The block takes one vertex at a time and works on it alone: the input
// stalls from the cycle after acceptance until the vertex is finished. A first
// vertex opens the path; each further vertex finds its segment length
// (a 33-step square root sharing one 32x32 multiplier), then works out each
// sample it produces (two 33-step divisions, one per coordinate), plus a skip
// division when the per-segment sample cap is hit. Ending a path adds a
// square root for the end gap and then the final results.
// Results leave through an output register, so a stalled output only holds
// the block when a further result is ready.
`default_nettype none

module polyline_arc_length_resampler_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [20:0]        i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic               i_path_end,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_sample_x,
    output logic signed [31:0]      o_sample_y,
    output logic                    o_sample_last,
    output logic                    o_cap_overflow
);

    palr_pkg::t_cmd  w_cmd;
    palr_pkg::t_stat w_stat;

    // Sequencer.
    palr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and path state.
    palr_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_path_end     (i_path_end),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_sample_x     (o_sample_x),
        .o_sample_y     (o_sample_y),
        .o_sample_last  (o_sample_last),
        .o_cap_overflow (o_cap_overflow),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Polyline arc-length resampler testbench
// Drives vertex paths through the resampler under random idling on both
// channels and checks every resampled point against a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
        logic               ovf;
    } sample_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               pend;
        logic               chk;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } vrow_t;

    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
    localparam longint unsigned MAX48V = 64'hFFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int SETTLE_CYCLES = 300;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [20:0]        i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic               i_path_end;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_sample_x;
    logic signed [31:0] o_sample_y;
    logic               o_sample_last;
    logic               o_cap_overflow;

    polyline_arc_length_resampler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_path_end     (i_path_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_x     (o_sample_x),
        .o_sample_y     (o_sample_y),
        .o_sample_last  (o_sample_last),
        .o_cap_overflow (o_cap_overflow)
    );

    // Predictor state: a mirror of the resampler's path state.
    logic [20:0]      spacing_reg;
    longint           last_x, last_y;
    logic             path_open;
    longint unsigned  path_length;
    longint unsigned  next_mark;
    longint           held_x, held_y;
    logic             held_ok;
    int unsigned      sample_tally;

    sample_t pending_samples[$];
    vrow_t   rows[$];
    int      mismatches;
    logic    quiet;
    int      idle_cycles;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Exact floor of the Euclidean distance between two points.
    function automatic longint unsigned seg_length(longint ax, longint ay,
                                                   longint bx, longint by);
        longint       dx, dy;
        logic [63:0]  ux, uy;
        logic [65:0]  sq;
        logic [67:0]  rem, trial;
        logic [33:0]  root;
        dx = bx - ax;
        dy = by - ay;
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        sq = ux * ux + uy * uy;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | 68'(sq[2*i +: 2]);
            trial = {32'd0, root, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = {root[32:0], 1'b1};
            end else begin
                root = {root[32:0], 1'b0};
            end
        end
        return 64'(root);
    endfunction

    // Linear interpolation, rounding the magnitude half away from zero.
    function automatic longint lerp_coord(longint a, longint b,
                                          longint unsigned off, longint unsigned len);
        longint       d;
        logic [127:0] prod, q, r;
        d = b - a;
        prod = 128'(d < 0 ? -d : d) * 128'(off);
        q = prod / 128'(len);
        r = prod % 128'(len);
        if (r >= 128'(len) - r) begin
            q = q + 1;
        end
        return d < 0 ? a - longint'(q) : a + longint'(q);
    endfunction

    function automatic longint unsigned sat48(longint unsigned v);
        return v > MAX48V ? MAX48V : v;
    endfunction

    // Builds one expected sample with the overflow flag still clear.
    function automatic sample_t make_sample(longint x, longint y, logic last);
        sample_t s;
        s.x = x[31:0];
        s.y = y[31:0];
        s.last = last;
        s.ovf = 1'b0;
        return s;
    endfunction

    // Appends one row to the directed stimulus table.
    function automatic void add_row(logic signed [31:0] x, logic signed [31:0] y,
                                    logic pend, logic chk,
                                    logic signed [31:0] ex, logic signed [31:0] ey);
        vrow_t v;
        v.x = x;
        v.y = y;
        v.pend = pend;
        v.chk = chk;
        v.ex = ex;
        v.ey = ey;
        rows = {rows, v};
    endfunction

    function automatic void clear_path_state();
        last_x = 0;
        last_y = 0;
        path_open = 1'b0;
        path_length = 0;
        next_mark = 0;
        held_x = 0;
        held_y = 0;
        held_ok = 1'b0;
        sample_tally = 0;
    endfunction

    // Works out the samples that one accepted vertex produces and queues them.
    function automatic int resample_vertex(logic signed [31:0] px, logic signed [31:0] py,
                                           logic pend);
        sample_t          step_out[$];
        longint           x, y, sx, sy;
        longint unsigned  sp, len, limit, off, skip, gap;
        logic             ovf;
        int               cnt;
        x = px;
        y = py;
        sp = spacing_reg == 0 ? 1 : 64'(spacing_reg);
        ovf = 1'b0;
        if (!path_open) begin
            last_x = x;
            last_y = y;
            path_open = 1'b1;
            path_length = 0;
            next_mark = sp;
            held_x = x;
            held_y = y;
            held_ok = 1'b1;
            sample_tally = 1;
        end else begin
            len = seg_length(last_x, last_y, x, y);
            if (len > palr_pkg::DUP_EPS_VAL && len > palr_pkg::SEG_EPS_VAL) begin
                limit = path_length + len + palr_pkg::SEG_EPS_VAL;
                cnt = 0;
                while (next_mark <= limit && cnt < palr_pkg::MAX_SEGMENT_SAMPLES) begin
                    off = next_mark >= path_length ? next_mark - path_length : 0;
                    if (off > len) begin
                        off = len;
                    end
                    sx = lerp_coord(last_x, x, off, len);
                    sy = lerp_coord(last_y, y, off, len);
                    if (held_ok) begin
                        step_out = {step_out, make_sample(held_x, held_y, 1'b0)};
                    end
                    held_x = sx;
                    held_y = sy;
                    held_ok = 1'b1;
                    if (sample_tally < 3) begin
                        sample_tally++;
                    end
                    cnt++;
                    next_mark = sat48(next_mark + sp);
                end
                if (next_mark <= limit) begin
                    skip = (limit - next_mark) / sp + 1;
                    ovf = 1'b1;
                    next_mark = sat48(next_mark + skip * sp);
                end
                path_length = sat48(path_length + len);
                last_x = x;
                last_y = y;
            end
        end
        // Path end: replace, append or emit the held sample alone.
        if (pend) begin
            gap = seg_length(held_x, held_y, last_x, last_y);
            if (gap > palr_pkg::DUP_EPS_VAL) begin
                if (sample_tally >= 2 && 2 * gap < sp) begin
                    step_out = {step_out, make_sample(last_x, last_y, 1'b1)};
                end else begin
                    step_out = {step_out, make_sample(held_x, held_y, 1'b0)};
                    step_out = {step_out, make_sample(last_x, last_y, 1'b1)};
                end
            end else begin
                step_out = {step_out, make_sample(held_x, held_y, 1'b1)};
            end
            clear_path_state();
        end
        foreach (step_out[k]) begin
            step_out[k].ovf = ovf;
            pending_samples = {pending_samples, step_out[k]};
        end
        return step_out.size();
    endfunction

    // Offers one vertex and waits for its transaction, then predicts it.
    task automatic put_vertex(logic signed [31:0] px, logic signed [31:0] py, logic pend,
                              output int produced);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        i_path_end <= pend;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        produced = resample_vertex(px, py, pend);
        @(negedge i_clk);
    endtask

    // Waits until the block has drained, then writes the spacing register.
    task automatic write_spacing(logic [20:0] value);
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        spacing_reg = value;
    endtask

    // Output side: random stall bursts, none once the run goes quiet.
    initial begin
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end
    end

    // Result checker: each output transaction against the oldest expectation.
    always @(posedge i_clk) begin
        sample_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected sample x=%0d y=%0d last=%0b ovf=%0b",
                             o_sample_x, o_sample_y, o_sample_last, o_cap_overflow);
                end
            end else begin
                want = pending_samples.pop_front();
                if (want.x !== o_sample_x || want.y !== o_sample_y ||
                    want.last !== o_sample_last || want.ovf !== o_cap_overflow) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Sample mismatch: expected x=%0d y=%0d last=%0b ovf=%0b, got x=%0d y=%0d last=%0b ovf=%0b",
                                 want.x, want.y, want.last, want.ovf,
                                 o_sample_x, o_sample_y, o_sample_last, o_cap_overflow);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        logic [20:0]      phase_spacing[7];
        logic signed [31:0] vx, vy, cx, cy;
        logic             vend;
        int               produced, left_in_path, step, sp_i, kind;
        sample_t          got;

        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_point_x = '0;
        i_point_y = '0;
        i_path_end = 1'b0;
        mismatches = 0;
        quiet = 1'b0;
        idle_cycles = 0;
        spacing_reg = 21'd3277;
        clear_path_state();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows at the reset spacing of 3277.
        // Single-vertex paths at the coordinate extremes.
        add_row(32'sd0, 32'sd0, 1'b1, 1'b1, 32'sd0, 32'sd0);
        add_row(CMAX, CMIN, 1'b1, 1'b1, CMAX, CMIN);
        add_row(CMIN, CMAX, 1'b1, 1'b1, CMIN, CMAX);
        // Duplicate vertex mid path, then a path end on a duplicate.
        add_row(32'sd0, 32'sd0, 1'b0, 1'b0, 0, 0);
        add_row(32'sd0, 32'sd0, 1'b0, 1'b0, 0, 0);
        add_row(32'sd10000, 32'sd0, 1'b0, 1'b0, 0, 0);
        add_row(32'sd10000, 32'sd0, 1'b1, 1'b0, 0, 0);
        // Endpoint on a sample, endpoint appended, endpoint replacing.
        add_row(32'sd0, 32'sd0, 1'b0, 1'b0, 0, 0);
        add_row(32'sd3277, 32'sd0, 1'b1, 1'b0, 0, 0);
        add_row(32'sd0, 32'sd0, 1'b0, 1'b0, 0, 0);
        add_row(32'sd5000, 32'sd0, 1'b1, 1'b0, 0, 0);
        add_row(32'sd0, 32'sd0, 1'b0, 1'b0, 0, 0);
        add_row(32'sd4000, 32'sd0, 1'b1, 1'b0, 0, 0);
        // Segments long enough to hit the per-segment sample cap.
        add_row(32'sd0, 32'sd0, 1'b0, 1'b0, 0, 0);
        add_row(32'sd1000000, 32'sd0, 1'b1, 1'b0, 0, 0);
        add_row(32'sd0, 32'sd0, 1'b0, 1'b0, 0, 0);
        add_row(-32'sd300000, -32'sd200000, 1'b1, 1'b0, 0, 0);
        add_row(CMIN, CMIN, 1'b0, 1'b0, 0, 0);
        add_row(CMAX, CMAX, 1'b0, 1'b0, 0, 0);
        add_row(CMIN, CMAX, 1'b1, 1'b0, 0, 0);
        foreach (rows[r]) begin
            put_vertex(rows[r].x, rows[r].y, rows[r].pend, produced);
            if (rows[r].chk) begin
                got = pending_samples[pending_samples.size() - 1];
                if (produced != 1 || got.x !== rows[r].ex || got.y !== rows[r].ey ||
                    got.last !== 1'b1 || got.ovf !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Directed row %0d: predicted sample differs from table", r);
                    end
                end
            end
        end

        // Random phases, each with its own spacing; a phase may stop mid path.
        phase_spacing = '{21'd3277, 21'd1, 21'h1F_FFFF, 21'd0, 21'd1048576, 21'd64,
                          21'($urandom_range(1, 1048576))};
        left_in_path = 0;
        cx = 0;
        cy = 0;
        for (int p = 0; p < 7; p++) begin
            write_spacing(phase_spacing[p]);
            if (p == 6) begin
                quiet = 1'b1;
            end
            sp_i = phase_spacing[p] == 0 ? 1 : int'(phase_spacing[p]);
            for (int n = 0; n < 36; n++) begin
                if (left_in_path == 0) begin
                    // New path start, sometimes at a coordinate extreme.
                    case ($urandom_range(0, 9))
                        0: begin vx = CMIN; vy = CMAX; end
                        1: begin vx = CMAX; vy = 0; end
                        default: begin vx = $urandom; vy = $urandom; end
                    endcase
                    left_in_path = $urandom_range(1, 8);
                end else begin
                    kind = $urandom_range(0, 19);
                    if (kind == 0) begin
                        vx = cx;
                        vy = cy;
                    end else if (kind == 1) begin
                        vx = $urandom;
                        vy = $urandom;
                    end else begin
                        step = sp_i * $urandom_range(0, 3) + $urandom_range(0, sp_i);
                        vx = cx + ($urandom_range(0, 1) ? step : -step);
                        step = sp_i * $urandom_range(0, 3) + $urandom_range(0, sp_i);
                        vy = cy + ($urandom_range(0, 1) ? step : -step);
                    end
                end
                left_in_path--;
                // Occasionally cut a path short.
                if ($urandom_range(0, 14) == 0) begin
                    left_in_path = 0;
                end
                vend = left_in_path == 0;
                cx = vx;
                cy = vy;
                put_vertex(vx, vy, vend, produced);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
